// ----- hdl/sdr_pkg.sv -----
package sdr_pkg;

	// Field widths fixed by the item and register formats.
	localparam int POS_W  = 12;
	localparam int SIDE_W = 7;
	localparam int PROB_W = 17;
	localparam int CELL_W = 2;
	localparam int OP_W   = 2;
	localparam int MODE_W = 2;
	localparam int RULE_W = 2;
	localparam int LC_W   = 13;
	// Mapped cell numbers stay below side*side, and side is at most 127.
	localparam int MAP_W  = 14;
	localparam int DIV_CNT_W = 4;

	localparam int MAX_SIDE_DEF = 64;

	localparam logic [PROB_W-1:0] HALF_Q16 = 17'd32768;

	// APB register map.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [1:0] REG_SIDE   = 2'd0;
	localparam logic [1:0] REG_MOVE   = 2'd1;
	localparam logic [1:0] REG_ATTACH = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_RST = 7'd10;
	localparam logic [PROB_W-1:0] PROB_RST = 17'd65536;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ID  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REV = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TR  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RTR = 2'd3;

	localparam logic [CELL_W-1:0] CELL_EMPTY   = 2'd0;
	localparam logic [CELL_W-1:0] CELL_WALKER  = 2'd1;
	localparam logic [CELL_W-1:0] CELL_CRYSTAL = 2'd2;

	localparam logic [RULE_W-1:0] RULE_NONE   = 2'd0;
	localparam logic [RULE_W-1:0] RULE_FWD    = 2'd1;
	localparam logic [RULE_W-1:0] RULE_BACK   = 2'd2;
	localparam logic [RULE_W-1:0] RULE_ATTACH = 2'd3;

	// Grid port operations requested by the controller.
	localparam logic [2:0] MEM_NONE   = 3'd0;
	localparam logic [2:0] MEM_RD_POS = 3'd1;
	localparam logic [2:0] MEM_WR_POS = 3'd2;
	localparam logic [2:0] MEM_RD_A   = 3'd3;
	localparam logic [2:0] MEM_RD_B   = 3'd4;
	localparam logic [2:0] MEM_WR_A   = 3'd5;
	localparam logic [2:0] MEM_WR_B   = 3'd6;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [POS_W-1:0]  position;
		logic [CELL_W-1:0] write_value;
		logic [MODE_W-1:0] scan_mode;
		logic [PROB_W-1:0] move_draw;
		logic [PROB_W-1:0] end_draw;
	} req_t;

	typedef struct packed {
		logic [CELL_W-1:0] read_value;
		logic [RULE_W-1:0] rule_applied;
	} rsp_t;

	typedef struct packed {
		logic       capture;
		logic       check;
		logic       div_step;
		logic       map_b;
		logic       map_a;
		logic       cap_va;
		logic       eval;
		logic       load_out;
		logic [2:0] mem_op;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] in_op;
		logic            sweep_go;
		logic            div_last;
		logic            out_block;
	} dp_stat_t;

	// Cell number visited at scan position pos, where q and r are the
	// quotient and remainder of pos by the side n. One multiplier only.
	function automatic logic [MAP_W-1:0] scan_map(
		input logic [POS_W-1:0]  pos,
		input logic [POS_W-1:0]  q,
		input logic [SIDE_W-1:0] r,
		input logic [SIDE_W-1:0] n,
		input logic [MAP_W-1:0]  total,
		input logic [MODE_W-1:0] mode
	);
		logic [MAP_W-1:0] m;
		logic [MAP_W-1:0] prod;
		logic [MAP_W-1:0] res;
		m = (mode == MODE_RTR) ? (MAP_W'(n) - MAP_W'(r) - MAP_W'(1)) : MAP_W'(r);
		prod = m * MAP_W'(n);
		unique case (mode)
			MODE_ID:  res = MAP_W'(pos);
			MODE_REV: res = total - MAP_W'(1) - MAP_W'(pos);
			MODE_TR:  res = prod + MAP_W'(q);
			MODE_RTR: res = prod + MAP_W'(n) - MAP_W'(q) - MAP_W'(1);
		endcase
		return res;
	endfunction

endpackage

// ----- hdl/sdr_if.sv -----
interface sdr_req_if;
	import sdr_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sdr_rsp_if;
	import sdr_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sdr_cfg.sv -----
module sdr_cfg import sdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [SIDE_W-1:0] side,
	output logic [PROB_W-1:0] move_prob,
	output logic [PROB_W-1:0] attach_prob
);

	logic [SIDE_W-1:0] side_q;
	logic [PROB_W-1:0] move_q;
	logic [PROB_W-1:0] attach_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= SIDE_RST;
			move_q   <= PROB_RST;
			attach_q <= PROB_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SIDE:   side_q   <= pwdata[SIDE_W-1:0];
				REG_MOVE:   move_q   <= pwdata[PROB_W-1:0];
				REG_ATTACH: attach_q <= pwdata[PROB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SIDE:   prdata = APB_DW'(side_q);
			REG_MOVE:   prdata = APB_DW'(move_q);
			REG_ATTACH: prdata = APB_DW'(attach_q);
			default:    prdata = '0;
		endcase
	end

	assign side        = side_q;
	assign move_prob   = move_q;
	assign attach_prob = attach_q;

endmodule

// ----- hdl/sdr_ctrl.sv -----
module sdr_ctrl import sdr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WR   = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_MAPB = 4'd5;
	localparam logic [3:0] S_MAPA = 4'd6;
	localparam logic [3:0] S_RDA  = 4'd7;
	localparam logic [3:0] S_RDB  = 4'd8;
	localparam logic [3:0] S_EVAL = 4'd9;
	localparam logic [3:0] S_WRA  = 4'd10;
	localparam logic [3:0] S_WRB  = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (stat.in_op)
						OP_WRITE: state_nx = S_WR;
						OP_READ:  state_nx = S_RD;
						OP_SWEEP: state_nx = S_CHK;
						default:  state_nx = S_DONE;
					endcase
				end
			end
			S_WR: begin
				cmd.mem_op = MEM_WR_POS;
				state_nx   = S_DONE;
			end
			S_RD: begin
				cmd.mem_op = MEM_RD_POS;
				state_nx   = S_DONE;
			end
			S_CHK: begin
				cmd.check = 1'b1;
				state_nx  = stat.sweep_go ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nx = S_MAPB;
				end
			end
			S_MAPB: begin
				cmd.map_b = 1'b1;
				state_nx  = S_MAPA;
			end
			S_MAPA: begin
				cmd.map_a = 1'b1;
				state_nx  = S_RDA;
			end
			S_RDA: begin
				cmd.mem_op = MEM_RD_A;
				state_nx   = S_RDB;
			end
			S_RDB: begin
				cmd.mem_op = MEM_RD_B;
				cmd.cap_va = 1'b1;
				state_nx   = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = S_WRA;
			end
			S_WRA: begin
				cmd.mem_op = MEM_WR_A;
				state_nx   = S_WRB;
			end
			S_WRB: begin
				cmd.mem_op = MEM_WR_B;
				state_nx   = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_block) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule

// ----- hdl/sdr_dp.sv -----
module sdr_dp import sdr_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              in_data,
	input  logic [SIDE_W-1:0] side,
	input  logic [PROB_W-1:0] move_prob,
	input  logic [PROB_W-1:0] attach_prob,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic              out_ready,
	output logic              out_valid,
	output rsp_t              out_data
);

	localparam int GRID_CELLS = MAX_SIDE * MAX_SIDE;
	localparam int AW  = $clog2(GRID_CELLS);
	localparam int PXW = (AW > POS_W) ? AW : POS_W;
	localparam int XW  = (AW > MAP_W) ? AW : MAP_W;
	localparam int SIDE_LIM = (MAX_SIDE > (1 << SIDE_W) - 1) ? (1 << SIDE_W) - 1 : MAX_SIDE;
	localparam logic [SIDE_W-1:0] N_MAX = SIDE_W'(SIDE_LIM);
	localparam logic [SIDE_W-1:0] N_MIN = SIDE_W'(2);

	// Grid memory, one port, registered read data.
	logic [CELL_W-1:0] grid_q [GRID_CELLS];
	logic [CELL_W-1:0] rd_data_q;

	req_t               item_q;
	logic [LC_W-1:0]    last_cut_q;
	logic [SIDE_W-1:0]  div_rem_q;
	logic [POS_W-1:0]   div_num_q;
	logic [POS_W-1:0]   div_quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [AW-1:0]      addr_a_q;
	logic [AW-1:0]      addr_b_q;
	logic [CELL_W-1:0]  va_q;
	logic [RULE_W-1:0]  rule_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic [SIDE_W-1:0]  n;
	logic [MAP_W-1:0]   total;
	logic               pos_in_grid;
	logic [PXW-1:0]     pos_x;
	logic [AW-1:0]      pos_idx;
	logic [MAP_W-1:0]   pos_w;
	logic               in_range;
	logic               cut;
	logic [LC_W-1:0]    lc_eff;
	logic [MAP_W-1:0]   gap;
	logic               gap2;

	logic [SIDE_W:0]    rem_sh;
	logic               rem_ge;
	logic [SIDE_W-1:0]  rem_nx;

	logic [POS_W-1:0]   m_pos;
	logic [POS_W-1:0]   m_q;
	logic [SIDE_W-1:0]  m_r;
	logic [MAP_W-1:0]   map_v;
	logic [XW-1:0]      map_x;
	logic [AW-1:0]      map_addr;

	logic               move_ok;
	logic               att_ok;
	logic [RULE_W-1:0]  rule_nx;
	logic [CELL_W-1:0]  new_a;
	logic [CELL_W-1:0]  new_b;

	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      mem_addr;
	logic [CELL_W-1:0]  mem_wdata;

	// Effective side and grid size from the side register.
	always_comb begin
		if (side < N_MIN) begin
			n = N_MIN;
		end else if (side > N_MAX) begin
			n = N_MAX;
		end else begin
			n = side;
		end
	end
	assign total = MAP_W'(n) * MAP_W'(n);

	assign pos_in_grid = (32'(item_q.position) < 32'(GRID_CELLS));
	assign pos_x       = PXW'(item_q.position);
	assign pos_idx     = pos_x[AW-1:0];

	// Cut decision for a sweep step.
	assign pos_w    = MAP_W'(item_q.position);
	assign in_range = pos_w < total;
	assign cut      = (item_q.end_draw <= HALF_Q16) || (pos_w == total - MAP_W'(1));
	assign lc_eff   = (item_q.position == '0) ? '1 : last_cut_q;
	assign gap      = pos_w - {lc_eff[LC_W-1], lc_eff};
	assign gap2     = (gap == MAP_W'(2));

	// One bit of restoring division per step.
	assign rem_sh = {div_rem_q, div_num_q[POS_W-1]};
	assign rem_ge = rem_sh >= {1'b0, n};
	assign rem_nx = rem_ge ? SIDE_W'(rem_sh - {1'b0, n}) : rem_sh[SIDE_W-1:0];

	// The cell before the current one: step the quotient and remainder back.
	always_comb begin
		if (cmd.map_a) begin
			m_pos = item_q.position - POS_W'(1);
			if (div_rem_q == '0) begin
				m_q = div_quo_q - POS_W'(1);
				m_r = n - SIDE_W'(1);
			end else begin
				m_q = div_quo_q;
				m_r = div_rem_q - SIDE_W'(1);
			end
		end else begin
			m_pos = item_q.position;
			m_q   = div_quo_q;
			m_r   = div_rem_q;
		end
	end
	assign map_v    = scan_map(m_pos, m_q, m_r, n, total, item_q.scan_mode);
	assign map_x    = XW'(map_v);
	assign map_addr = map_x[AW-1:0];

	// Rewrite rules on the pair (a, b).
	assign move_ok = item_q.move_draw <= move_prob;
	assign att_ok  = item_q.move_draw <= attach_prob;

	always_comb begin
		priority if (va_q == CELL_WALKER && rd_data_q == CELL_EMPTY && move_ok) begin
			rule_nx = RULE_FWD;
		end else if (va_q == CELL_EMPTY && rd_data_q == CELL_WALKER && move_ok) begin
			rule_nx = RULE_BACK;
		end else if (va_q == CELL_WALKER && rd_data_q == CELL_CRYSTAL && att_ok) begin
			rule_nx = RULE_ATTACH;
		end else begin
			rule_nx = RULE_NONE;
		end
	end

	always_comb begin
		unique case (rule_q)
			RULE_FWD: begin
				new_a = CELL_EMPTY;
				new_b = CELL_WALKER;
			end
			RULE_BACK: begin
				new_a = CELL_WALKER;
				new_b = CELL_EMPTY;
			end
			RULE_ATTACH: begin
				new_a = CELL_CRYSTAL;
				new_b = CELL_CRYSTAL;
			end
			RULE_NONE: begin
				new_a = CELL_EMPTY;
				new_b = CELL_EMPTY;
			end
		endcase
	end

	// Grid port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = pos_idx;
		mem_wdata = item_q.write_value;
		unique case (cmd.mem_op)
			MEM_RD_POS: mem_re = 1'b1;
			MEM_WR_POS: mem_we = pos_in_grid;
			MEM_RD_A: begin
				mem_re   = 1'b1;
				mem_addr = addr_a_q;
			end
			MEM_RD_B: begin
				mem_re   = 1'b1;
				mem_addr = addr_b_q;
			end
			MEM_WR_A: begin
				mem_we    = (rule_q != RULE_NONE);
				mem_addr  = addr_a_q;
				mem_wdata = new_a;
			end
			MEM_WR_B: begin
				mem_we    = (rule_q != RULE_NONE);
				mem_addr  = addr_b_q;
				mem_wdata = new_b;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= grid_q[mem_addr];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
			rule_q <= RULE_NONE;
		end else if (cmd.eval) begin
			rule_q <= rule_nx;
		end
		if (cmd.check) begin
			div_rem_q <= '0;
			div_num_q <= item_q.position;
			div_quo_q <= '0;
		end else if (cmd.div_step) begin
			div_rem_q <= rem_nx;
			div_num_q <= {div_num_q[POS_W-2:0], 1'b0};
			div_quo_q <= {div_quo_q[POS_W-2:0], rem_ge};
		end
		if (cmd.map_b) begin
			addr_b_q <= map_addr;
		end
		if (cmd.map_a) begin
			addr_a_q <= map_addr;
		end
		if (cmd.cap_va) begin
			va_q <= rd_data_q;
		end
		if (cmd.load_out) begin
			out_q.read_value   <= (item_q.operation == OP_READ && pos_in_grid) ?
				rd_data_q : CELL_EMPTY;
			out_q.rule_applied <= rule_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cut_q  <= '1;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.check && in_range) begin
				if (cut) begin
					last_cut_q <= LC_W'(item_q.position);
				end else if (item_q.position == '0) begin
					last_cut_q <= '1;
				end
			end
			if (cmd.check) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.in_op     = in_data.operation;
	assign stat.sweep_go  = in_range && cut && gap2;
	assign stat.div_last  = (div_cnt_q == DIV_CNT_W'(POS_W - 1));
	assign stat.out_block = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hdl/stochastic_dendrite_rewrite_step.sv -----
// The block takes one item at a time. An unknown operation, a cell write, a cell read
// and a sweep step whose cut closes no two-cell substring take the short path; a sweep
// step whose cut closes a two-cell substring takes the longest, as the twelve one-bit
// divider steps that split the step index lie on its path.
// Reset (arst_n, asynchronous, active low) clears the controller, the last cut (to minus
// one) and the output valid flag, and restores side 10 and both probabilities to one.
module stochastic_dendrite_rewrite_step import sdr_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	sdr_req_if.sink           req,
	sdr_rsp_if.source         rsp
);

	// The block is split into three parts. The register file holds the side
	// and the two probabilities behind the APB port. The controller walks one
	// item at a time through its steps and the datapath holds the item, the
	// grid memory, the divider, the scan-order mapper and the output register.
	// The grid is not cleared by reset: a cell reads back undefined until it
	// has been written.

	logic [SIDE_W-1:0] side;
	logic [PROB_W-1:0] move_prob;
	logic [PROB_W-1:0] attach_prob;
	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic              in_ready;

	sdr_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.side        (side),
		.move_prob   (move_prob),
		.attach_prob (attach_prob)
	);

	// The controller accepts a transaction only from its idle state. A
	// finished result sits in the output register, so the next item can be
	// taken and worked on while that result still waits; the controller only
	// holds in its final state when the register is still occupied.
	sdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	// A sweep step first decides whether the cut closes a two-cell substring.
	// Only then does it divide the step index by the side, map both scan
	// positions to cells, read the pair, apply the rewrite rule and write the
	// pair back, one grid access per cycle.
	sdr_dp #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (req.data),
		.side        (side),
		.move_prob   (move_prob),
		.attach_prob (attach_prob),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_data    (rsp.data)
	);

endmodule
